FILE: sv/humidity_temperature_compensation_unit_defines.svh
// Assertion macros shared by the compensation unit RTL.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH

// checked only while out of reset
`define HTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/htc_pkg.sv
// Types, constants and microcode ROM for the compensation unit.
package htc_pkg;

    typedef struct packed {
        logic        operation;
        logic [19:0] raw_value;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] reading;
    } t_out;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic        [31:0] h45;
        logic signed [7:0]  h6;
    } t_coefs;

    // configuration register indexes
    localparam logic [2:0] CFG_T1  = 3'd0;
    localparam logic [2:0] CFG_T2  = 3'd1;
    localparam logic [2:0] CFG_T3  = 3'd2;
    localparam logic [2:0] CFG_H1  = 3'd3;
    localparam logic [2:0] CFG_H2  = 3'd4;
    localparam logic [2:0] CFG_H3  = 3'd5;
    localparam logic [2:0] CFG_H45 = 3'd6;
    localparam logic [2:0] CFG_H6  = 3'd7;

    localparam logic OPN_TEMP = 1'b0;
    localparam logic OPN_HUM  = 1'b1;

    // datapath operations
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_SHL   = 3'd3;
    localparam logic [2:0] OP_ASR   = 3'd4;
    localparam logic [2:0] OP_CLAMP = 3'd5;
    localparam logic [2:0] OP_JHUM  = 3'd6;

    // operand sources
    localparam logic [3:0] SRC_R0   = 4'd0;
    localparam logic [3:0] SRC_R1   = 4'd1;
    localparam logic [3:0] SRC_R2   = 4'd2;
    localparam logic [3:0] SRC_R3   = 4'd3;
    localparam logic [3:0] SRC_RAW  = 4'd4;
    localparam logic [3:0] SRC_FINE = 4'd5;
    localparam logic [3:0] SRC_T1   = 4'd6;
    localparam logic [3:0] SRC_T2   = 4'd7;
    localparam logic [3:0] SRC_T3   = 4'd8;
    localparam logic [3:0] SRC_H1   = 4'd9;
    localparam logic [3:0] SRC_H2   = 4'd10;
    localparam logic [3:0] SRC_H3   = 4'd11;
    localparam logic [3:0] SRC_H4   = 4'd12;
    localparam logic [3:0] SRC_H5   = 4'd13;
    localparam logic [3:0] SRC_H6   = 4'd14;
    localparam logic [3:0] SRC_K    = 4'd15;

    localparam logic [1:0] R0 = 2'd0;
    localparam logic [1:0] R1 = 2'd1;
    localparam logic [1:0] R2 = 2'd2;
    localparam logic [1:0] R3 = 2'd3;

    // constant table indexes
    localparam logic [2:0] K_76800   = 3'd0;
    localparam logic [2:0] K_16384   = 3'd1;
    localparam logic [2:0] K_32768   = 3'd2;
    localparam logic [2:0] K_2097152 = 3'd3;
    localparam logic [2:0] K_8192    = 3'd4;
    localparam logic [2:0] K_HUM_MAX = 3'd5;
    localparam logic [2:0] K_128     = 3'd6;
    localparam logic [2:0] K_5       = 3'd7;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_HUM  = 6'd16;
    localparam logic [PC_W-1:0] PC_LAST = 6'd43;

    typedef struct packed {
        logic [2:0]      op;
        logic            wr;
        logic [1:0]      dst;
        logic [3:0]      srca;
        logic [3:0]      srcb;
        logic [4:0]      sh;
        logic [2:0]      kidx;
        logic            wr_fine;
        logic            done;
        logic [PC_W-1:0] tgt;
    } t_uop;

    function automatic logic [31:0] const_val(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            K_76800:   v = 32'd76800;
            K_16384:   v = 32'd16384;
            K_32768:   v = 32'd32768;
            K_2097152: v = 32'd2097152;
            K_8192:    v = 32'd8192;
            K_HUM_MAX: v = 32'd419430400;
            K_128:     v = 32'd128;
            K_5:       v = 32'd5;
            default:   v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_uop mk(input logic [2:0] op, input logic [1:0] dst,
                                input logic [3:0] a, input logic [3:0] b,
                                input logic [4:0] sh, input logic [2:0] k,
                                input logic wf, input logic dn);
        t_uop u;
        u.op      = op;
        u.wr      = (op != OP_JHUM);
        u.dst     = dst;
        u.srca    = a;
        u.srcb    = b;
        u.sh      = sh;
        u.kidx    = k;
        u.wr_fine = wf;
        u.done    = dn;
        u.tgt     = PC_HUM;
        return u;
    endfunction

    // microcode: temperature at 1..15, humidity at PC_HUM..PC_LAST
    function automatic t_uop rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_JHUM, R0, SRC_R0, SRC_R0, 5'd0, K_5, 1'b0, 1'b0);
            6'd1:  u = mk(OP_ASR, R0, SRC_RAW, SRC_R0, 5'd3, K_5, 1'b0, 1'b0);
            6'd2:  u = mk(OP_SHL, R1, SRC_T1, SRC_R0, 5'd1, K_5, 1'b0, 1'b0);
            6'd3:  u = mk(OP_SUB, R0, SRC_R0, SRC_R1, 5'd0, K_5, 1'b0, 1'b0);
            6'd4:  u = mk(OP_MUL, R0, SRC_R0, SRC_T2, 5'd0, K_5, 1'b0, 1'b0);
            6'd5:  u = mk(OP_ASR, R0, SRC_R0, SRC_R0, 5'd11, K_5, 1'b0, 1'b0);
            6'd6:  u = mk(OP_ASR, R1, SRC_RAW, SRC_R0, 5'd4, K_5, 1'b0, 1'b0);
            6'd7:  u = mk(OP_SUB, R1, SRC_R1, SRC_T1, 5'd0, K_5, 1'b0, 1'b0);
            6'd8:  u = mk(OP_MUL, R1, SRC_R1, SRC_R1, 5'd0, K_5, 1'b0, 1'b0);
            6'd9:  u = mk(OP_ASR, R1, SRC_R1, SRC_R0, 5'd12, K_5, 1'b0, 1'b0);
            6'd10: u = mk(OP_MUL, R1, SRC_R1, SRC_T3, 5'd0, K_5, 1'b0, 1'b0);
            6'd11: u = mk(OP_ASR, R1, SRC_R1, SRC_R0, 5'd14, K_5, 1'b0, 1'b0);
            6'd12: u = mk(OP_ADD, R0, SRC_R0, SRC_R1, 5'd0, K_5, 1'b1, 1'b0);
            6'd13: u = mk(OP_MUL, R0, SRC_R0, SRC_K, 5'd0, K_5, 1'b0, 1'b0);
            6'd14: u = mk(OP_ADD, R0, SRC_R0, SRC_K, 5'd0, K_128, 1'b0, 1'b0);
            6'd15: u = mk(OP_ASR, R0, SRC_R0, SRC_R0, 5'd8, K_5, 1'b0, 1'b1);
            6'd16: u = mk(OP_SUB, R0, SRC_FINE, SRC_K, 5'd0, K_76800, 1'b0, 1'b0);
            6'd17: u = mk(OP_SHL, R1, SRC_RAW, SRC_R0, 5'd14, K_5, 1'b0, 1'b0);
            6'd18: u = mk(OP_SHL, R2, SRC_H4, SRC_R0, 5'd20, K_5, 1'b0, 1'b0);
            6'd19: u = mk(OP_SUB, R1, SRC_R1, SRC_R2, 5'd0, K_5, 1'b0, 1'b0);
            6'd20: u = mk(OP_MUL, R2, SRC_H5, SRC_R0, 5'd0, K_5, 1'b0, 1'b0);
            6'd21: u = mk(OP_SUB, R1, SRC_R1, SRC_R2, 5'd0, K_5, 1'b0, 1'b0);
            6'd22: u = mk(OP_ADD, R1, SRC_R1, SRC_K, 5'd0, K_16384, 1'b0, 1'b0);
            6'd23: u = mk(OP_ASR, R1, SRC_R1, SRC_R0, 5'd15, K_5, 1'b0, 1'b0);
            6'd24: u = mk(OP_MUL, R2, SRC_R0, SRC_H6, 5'd0, K_5, 1'b0, 1'b0);
            6'd25: u = mk(OP_ASR, R2, SRC_R2, SRC_R0, 5'd10, K_5, 1'b0, 1'b0);
            6'd26: u = mk(OP_MUL, R3, SRC_R0, SRC_H3, 5'd0, K_5, 1'b0, 1'b0);
            6'd27: u = mk(OP_ASR, R3, SRC_R3, SRC_R0, 5'd11, K_5, 1'b0, 1'b0);
            6'd28: u = mk(OP_ADD, R3, SRC_R3, SRC_K, 5'd0, K_32768, 1'b0, 1'b0);
            6'd29: u = mk(OP_MUL, R2, SRC_R2, SRC_R3, 5'd0, K_5, 1'b0, 1'b0);
            6'd30: u = mk(OP_ASR, R2, SRC_R2, SRC_R0, 5'd10, K_5, 1'b0, 1'b0);
            6'd31: u = mk(OP_ADD, R2, SRC_R2, SRC_K, 5'd0, K_2097152, 1'b0, 1'b0);
            6'd32: u = mk(OP_MUL, R2, SRC_R2, SRC_H2, 5'd0, K_5, 1'b0, 1'b0);
            6'd33: u = mk(OP_ADD, R2, SRC_R2, SRC_K, 5'd0, K_8192, 1'b0, 1'b0);
            6'd34: u = mk(OP_ASR, R2, SRC_R2, SRC_R0, 5'd14, K_5, 1'b0, 1'b0);
            6'd35: u = mk(OP_MUL, R1, SRC_R1, SRC_R2, 5'd0, K_5, 1'b0, 1'b0);
            6'd36: u = mk(OP_ASR, R2, SRC_R1, SRC_R0, 5'd15, K_5, 1'b0, 1'b0);
            6'd37: u = mk(OP_MUL, R2, SRC_R2, SRC_R2, 5'd0, K_5, 1'b0, 1'b0);
            6'd38: u = mk(OP_ASR, R2, SRC_R2, SRC_R0, 5'd7, K_5, 1'b0, 1'b0);
            6'd39: u = mk(OP_MUL, R2, SRC_R2, SRC_H1, 5'd0, K_5, 1'b0, 1'b0);
            6'd40: u = mk(OP_ASR, R2, SRC_R2, SRC_R0, 5'd4, K_5, 1'b0, 1'b0);
            6'd41: u = mk(OP_SUB, R1, SRC_R1, SRC_R2, 5'd0, K_5, 1'b0, 1'b0);
            6'd42: u = mk(OP_CLAMP, R1, SRC_R1, SRC_K, 5'd0, K_HUM_MAX, 1'b0, 1'b0);
            6'd43: u = mk(OP_ASR, R1, SRC_R1, SRC_R0, 5'd12, K_5, 1'b0, 1'b1);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

FILE: sv/htc_datapath.sv
// Datapath: working registers, fine temperature, shared multiplier/adder/shifter.
module htc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  htc_pkg::t_in         i_in,
    input  logic                 i_step,
    input  htc_pkg::t_uop        i_uop,
    input  htc_pkg::t_coefs      i_coefs,
    output logic [31:0]          o_alu
);

    logic [19:0] r_raw;
    logic [31:0] r_r0, r_r1, r_r2, r_r3;
    logic [31:0] r_fine;
    logic [31:0] a, b;

    function automatic logic [31:0] pick(
        input logic [3:0] s, input logic [31:0] r0, input logic [31:0] r1,
        input logic [31:0] r2, input logic [31:0] r3, input logic [19:0] raw,
        input logic [31:0] fine, input htc_pkg::t_coefs c, input logic [2:0] k);
        logic [31:0] v;
        case (s)
            htc_pkg::SRC_R0:   v = r0;
            htc_pkg::SRC_R1:   v = r1;
            htc_pkg::SRC_R2:   v = r2;
            htc_pkg::SRC_R3:   v = r3;
            htc_pkg::SRC_RAW:  v = {12'd0, raw};
            htc_pkg::SRC_FINE: v = fine;
            htc_pkg::SRC_T1:   v = {16'd0, c.t1};
            htc_pkg::SRC_T2:   v = {{16{c.t2[15]}}, c.t2};
            htc_pkg::SRC_T3:   v = {{16{c.t3[15]}}, c.t3};
            htc_pkg::SRC_H1:   v = {24'd0, c.h1};
            htc_pkg::SRC_H2:   v = {{16{c.h2[15]}}, c.h2};
            htc_pkg::SRC_H3:   v = {24'd0, c.h3};
            htc_pkg::SRC_H4:   v = {{16{c.h45[15]}}, c.h45[15:0]};
            htc_pkg::SRC_H5:   v = {{16{c.h45[31]}}, c.h45[31:16]};
            htc_pkg::SRC_H6:   v = {{24{c.h6[7]}}, c.h6};
            htc_pkg::SRC_K:    v = htc_pkg::const_val(k);
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign a = pick(i_uop.srca, r_r0, r_r1, r_r2, r_r3, r_raw, r_fine, i_coefs, i_uop.kidx);
    assign b = pick(i_uop.srcb, r_r0, r_r1, r_r2, r_r3, r_raw, r_fine, i_coefs, i_uop.kidx);

    always_comb begin
        case (i_uop.op)
            htc_pkg::OP_ADD: o_alu = a + b;
            htc_pkg::OP_SUB: o_alu = a - b;
            htc_pkg::OP_MUL: o_alu = a * b;    // low word only, wraps
            htc_pkg::OP_SHL: o_alu = a << i_uop.sh;
            htc_pkg::OP_ASR: o_alu = $unsigned($signed(a) >>> i_uop.sh);
            htc_pkg::OP_CLAMP: begin
                if (a[31]) begin
                    o_alu = '0;
                end else if ($signed(a) > $signed(b)) begin
                    o_alu = b;
                end else begin
                    o_alu = a;
                end
            end
            default: o_alu = a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            // humidity uses the low 16 raw bits only
            r_raw <= (i_in.operation == htc_pkg::OPN_HUM) ?
                     {4'd0, i_in.raw_value[15:0]} : i_in.raw_value;
        end
        if (i_step && i_uop.wr) begin
            case (i_uop.dst)
                htc_pkg::R0: r_r0 <= o_alu;
                htc_pkg::R1: r_r1 <= o_alu;
                htc_pkg::R2: r_r2 <= o_alu;
                htc_pkg::R3: r_r3 <= o_alu;
                default:     r_r0 <= o_alu;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine <= '0;
        end else if (i_step && i_uop.wr_fine) begin
            r_fine <= o_alu;
        end
    end

endmodule

FILE: sv/humidity_temperature_compensation_unit.sv
// Top level: config registers, microcode sequencer and output register.
//
// Input channel (i_in_valid/o_in_ready, payload i_in): one raw reading per
// request, tagged temperature or humidity. Output channel (o_out_valid/
// i_out_ready, payload o_out): one result per request, kind echoed.
// Configuration: i_cfg_we writes i_cfg_wdata into coefficient i_cfg_idx at
// the clock edge; write only while no request is in flight.
// One request is worked at a time by a microcode program that runs one step
// per cycle through a single shared multiply/add/shift datapath.
// Each request runs one dispatch step plus 15 program steps for temperature
// or 28 for humidity; o_in_ready stays low until the program ends.
// A finished result sits in an output register, so a new request is taken
// while the receiver stalls; if the next result finishes while the old one
// is still not taken, the sequencer holds on its last step.
// Reset (synchronous, i_rst_n low) clears coefficients, the stored fine
// temperature, the sequencer and the output valid.
`include "humidity_temperature_compensation_unit_defines.svh"

module humidity_temperature_compensation_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  htc_pkg::t_in         i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output htc_pkg::t_out        o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata
);

    htc_pkg::t_coefs             r_coefs;
    logic                        r_busy;
    logic [htc_pkg::PC_W-1:0]    r_pc;
    logic                        r_op;
    logic                        r_out_valid;
    htc_pkg::t_out               r_out;

    htc_pkg::t_uop               uop;
    logic                        accept;
    logic                        out_free;
    logic                        advance;
    logic [31:0]                 alu;

    assign uop      = htc_pkg::rom(r_pc);
    assign o_in_ready = !r_busy;
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = r_busy && (!uop.done || out_free);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                htc_pkg::CFG_T1:  r_coefs.t1  <= i_cfg_wdata[15:0];
                htc_pkg::CFG_T2:  r_coefs.t2  <= i_cfg_wdata[15:0];
                htc_pkg::CFG_T3:  r_coefs.t3  <= i_cfg_wdata[15:0];
                htc_pkg::CFG_H1:  r_coefs.h1  <= i_cfg_wdata[7:0];
                htc_pkg::CFG_H2:  r_coefs.h2  <= i_cfg_wdata[15:0];
                htc_pkg::CFG_H3:  r_coefs.h3  <= i_cfg_wdata[7:0];
                htc_pkg::CFG_H45: r_coefs.h45 <= i_cfg_wdata;
                htc_pkg::CFG_H6:  r_coefs.h6  <= i_cfg_wdata[7:0];
                default:          r_coefs     <= r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_op   <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
            r_op   <= i_in.operation;
        end else if (advance) begin
            if (uop.done) begin
                r_busy <= 1'b0;
            end else if (uop.op == htc_pkg::OP_JHUM && r_op == htc_pkg::OPN_HUM) begin
                r_pc <= uop.tgt;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && uop.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && uop.done) begin
            r_out.kind    <= r_op;
            r_out.reading <= alu;
        end
    end

    htc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_in    (i_in),
        .i_step  (advance),
        .i_uop   (uop),
        .i_coefs (r_coefs),
        .o_alu   (alu)
    );

    `HTC_ASSERT(a_accept_starts, (accept |=> (r_busy && r_pc == '0)), "request did not start program")
    `HTC_ASSERT(a_pc_range, (r_busy |-> (r_pc <= htc_pkg::PC_LAST)), "program counter ran off ROM")
    `HTC_ASSERT(a_hold_on_stall, ((r_busy && uop.done && r_out_valid && !i_out_ready) |=> (r_busy && $stable(r_pc))), "result lost while output stalled")
    `HTC_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n |=> (!r_busy && !o_out_valid)), "reset did not idle the unit")

endmodule

FILE: bench/htc_result_checker.sv
// Result checker for the compensation unit: predicts each reading and compares it.
module htc_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  htc_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  htc_pkg::t_out i_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata,
    output int            o_mismatches,
    output int            o_pending
);
    import htc_pkg::*;

    t_coefs coefs;
    int     fine_t;
    t_out   expected_readings[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // All intermediates are 32-bit signed; int arithmetic wraps and >>> floors.
    function automatic int temp_reading(input t_coefs c, input logic [19:0] raw,
                                        output int fine);
        int r, c1, c2, c3, d1, d2, v1, v2;
        r  = int'({12'd0, raw});
        c1 = int'({16'd0, c.t1});
        c2 = int'($signed(c.t2));
        c3 = int'($signed(c.t3));
        d1 = (r >>> 3) - (c1 <<< 1);
        v1 = (d1 * c2) >>> 11;
        d2 = (r >>> 4) - c1;
        v2 = (((d2 * d2) >>> 12) * c3) >>> 14;
        fine = v1 + v2;
        return (fine * 5 + 128) >>> 8;
    endfunction

    function automatic int hum_reading(input t_coefs c, input logic [19:0] raw,
                                       input int fine);
        int r, h1, h2, h3, h4, h5, h6, x, a, b, q;
        r  = int'({16'd0, raw[15:0]});
        h1 = int'({24'd0, c.h1});
        h2 = int'($signed(c.h2));
        h3 = int'({24'd0, c.h3});
        h4 = int'($signed(c.h45[15:0]));
        h5 = int'($signed(c.h45[31:16]));
        h6 = int'($signed(c.h6));
        x = fine - 76800;
        a = ((r <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
        b = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
        b = ((b >>> 10) + 2097152) * h2 + 8192;
        b = b >>> 14;
        x = a * b;
        q = x >>> 15;
        x = x - ((((q * q) >>> 7) * h1) >>> 4);
        if (x < 0)
            return 0;
        if (x > 419430400)
            x = 419430400;
        return x >>> 12;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        o_mismatches++;
        $display("%0t: %s: got %0d (0x%08h), expected %0d (0x%08h)",
                 $time, what, $signed(got), got, $signed(want), want);
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            coefs  = '0;
            fine_t = 0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_T1:  coefs.t1  = i_cfg_wdata[15:0];
                    CFG_T2:  coefs.t2  = i_cfg_wdata[15:0];
                    CFG_T3:  coefs.t3  = i_cfg_wdata[15:0];
                    CFG_H1:  coefs.h1  = i_cfg_wdata[7:0];
                    CFG_H2:  coefs.h2  = i_cfg_wdata[15:0];
                    CFG_H3:  coefs.h3  = i_cfg_wdata[7:0];
                    CFG_H45: coefs.h45 = i_cfg_wdata;
                    CFG_H6:  coefs.h6  = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // results always trail their requests, so retire before predicting
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    flag_mismatch("result with no request pending", i_out.reading, 32'd0);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out.kind !== want.kind)
                        flag_mismatch("kind", 32'(i_out.kind), 32'(want.kind));
                    if (i_out.reading !== want.reading)
                        flag_mismatch("reading", i_out.reading, want.reading);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.kind = i_in.operation;
                if (i_in.operation == OPN_TEMP)
                    want.reading = temp_reading(coefs, i_in.raw_value, fine_t);
                else
                    want.reading = hum_reading(coefs, i_in.raw_value, fine_t);
                expected_readings.push_back(want);
            end
        end
        o_pending <= expected_readings.size();
    end

endmodule

FILE: bench/tb.sv
// Testbench top: drives readings and coefficient sets into the compensation unit.
module tb;
    import htc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    int mismatches;
    int pending;
    int burst_left;
    int items_sent;
    int temps_sent;
    int hums_sent;
    int coef_sets;
    int ready_left;
    logic ready_level;

    humidity_temperature_compensation_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    htc_result_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: runs of ready and stalls, now and then a long stall
    always @(posedge i_clk) begin
        int pick;
        if (ready_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(1, 60);
            end else if (pick < 8) begin
                ready_level = ~ready_level;
                ready_left  = $urandom_range(1, 6);
            end else if (pick == 8) begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(20, 80);
            end else begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(1, 3);
            end
        end else begin
            ready_left--;
        end
        i_out_ready <= ready_level;
    end

    // Called just after the clock rises; returns once the unit has taken the request.
    task automatic send_reading(input logic op, input logic [19:0] raw);
        t_in item;
        int  gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 6);
        end
        item.operation = op;
        item.raw_value = raw;
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (op == OPN_TEMP)
            temps_sent++;
        else
            hums_sent++;
        burst_left--;
        if (burst_left == 0)
            i_in_valid <= 1'b0;
    endtask

    // Wait for every outstanding result, then let the sequencer go quiet.
    task automatic settle();
        // a finished burst has already dropped valid in this time step
        if (burst_left != 0)
            i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_coefs(input t_coefs c, input bit junk);
        logic [31:0] j;
        logic [31:0] w;
        logic [2:0]  idx;
        for (int k = 0; k < 8; k++) begin
            idx = 3'(k);
            j = junk ? $urandom : 32'd0;
            case (idx)
                CFG_T1:  w = {j[31:16], c.t1};
                CFG_T2:  w = {j[31:16], c.t2};
                CFG_T3:  w = {j[31:16], c.t3};
                CFG_H1:  w = {j[31:8], c.h1};
                CFG_H2:  w = {j[31:16], c.h2};
                CFG_H3:  w = {j[31:8], c.h3};
                CFG_H45: w = c.h45;
                default: w = {j[31:8], c.h6};
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= w;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        coef_sets++;
    endtask

    function automatic t_coefs random_coefs();
        t_coefs c;
        if ($urandom_range(0, 2) != 0) begin
            // near a real part's trim values
            c.t1  = 16'($urandom_range(26000, 29000));
            c.t2  = 16'($urandom_range(25000, 27500));
            c.t3  = 16'(int'($urandom_range(0, 2000)) - 1500);
            c.h1  = 8'($urandom_range(0, 100));
            c.h2  = 16'($urandom_range(300, 420));
            c.h3  = 8'($urandom_range(0, 30));
            c.h45 = {16'($urandom_range(0, 60)), 16'($urandom_range(250, 400))};
            c.h6  = 8'($urandom_range(20, 40));
        end else begin
            c.t1  = 16'($urandom);
            c.t2  = 16'($urandom);
            c.t3  = 16'($urandom);
            c.h1  = 8'($urandom);
            c.h2  = 16'($urandom);
            c.h3  = 8'($urandom);
            c.h45 = $urandom;
            c.h6  = 8'($urandom);
        end
        return c;
    endfunction

    task automatic send_edge_readings();
        send_reading(OPN_TEMP, 20'h00000);
        send_reading(OPN_HUM, 20'h00000);
        send_reading(OPN_TEMP, 20'hFFFFF);
        send_reading(OPN_HUM, 20'hFFFFF);
    endtask

    // Mostly a temperature followed by humidity readings; the rest is noise.
    task automatic random_readings();
        int n;
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) != 0)
                send_reading(OPN_TEMP, 20'($urandom_range(450000, 580000)));
            else
                send_reading(OPN_TEMP, 20'($urandom));
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 3) != 0)
                    send_reading(OPN_HUM, {4'($urandom), 16'($urandom_range(15000, 50000))});
                else
                    send_reading(OPN_HUM, 20'($urandom));
            end
        end else begin
            send_reading(1'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        t_coefs c;
        int goal;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        i_out_ready <= 1'b0;
        ready_left  = 0;
        ready_level = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        temps_sent  = 0;
        hums_sent   = 0;
        coef_sets   = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients; humidity first, so it sees the reset fine temperature
        send_reading(OPN_HUM, 20'h00000);
        send_reading(OPN_HUM, 20'hFFFFF);
        send_reading(OPN_TEMP, 20'h00000);
        send_reading(OPN_TEMP, 20'hFFFFF);
        send_reading(OPN_HUM, 20'h0FFFF);
        settle();

        // typical trim: clamps at both ends and ignored upper humidity bits
        c.t1 = 16'd27504; c.t2 = 16'd26435; c.t3 = -16'sd1000;
        c.h1 = 8'd75; c.h2 = 16'd362; c.h3 = 8'd0;
        c.h45 = {16'd50, 16'd313}; c.h6 = 8'd30;
        load_coefs(c, 1'b0);
        send_reading(OPN_TEMP, 20'd519888);
        send_reading(OPN_HUM, 20'h06A00);
        send_reading(OPN_HUM, 20'h00000);
        send_reading(OPN_HUM, 20'h0FFFF);
        send_reading(OPN_HUM, 20'hF6A00);
        send_reading(OPN_TEMP, 20'h00000);
        send_reading(OPN_HUM, 20'h08000);
        send_reading(OPN_TEMP, 20'hFFFFF);
        send_reading(OPN_HUM, 20'h08000);
        settle();

        c.t1 = 16'hFFFF; c.t2 = 16'h7FFF; c.t3 = 16'h7FFF;
        c.h1 = 8'hFF; c.h2 = 16'h7FFF; c.h3 = 8'hFF;
        c.h45 = 32'h7FFF_7FFF; c.h6 = 8'h7F;
        load_coefs(c, 1'b0);
        send_edge_readings();
        settle();

        c.t1 = 16'h0000; c.t2 = 16'h8000; c.t3 = 16'h8000;
        c.h1 = 8'h00; c.h2 = 16'h8000; c.h3 = 8'h00;
        c.h45 = 32'h8000_8000; c.h6 = 8'h80;
        load_coefs(c, 1'b0);
        send_edge_readings();
        settle();

        c.t1 = 16'hFFFF; c.t2 = 16'hFFFF; c.t3 = 16'hFFFF;
        c.h1 = 8'hFF; c.h2 = 16'hFFFF; c.h3 = 8'hFF;
        c.h45 = 32'hFFFF_FFFF; c.h6 = 8'hFF;
        load_coefs(c, 1'b0);
        send_edge_readings();
        settle();

        for (int p = 0; p < 12; p++) begin
            load_coefs(random_coefs(), 1'b1);
            goal = items_sent + 70;
            while (items_sent < goal)
                random_readings();
            settle();
        end

        $display("Covered %0d temperature and %0d humidity readings over %0d coefficient sets,",
                 temps_sent, hums_sent, coef_sets);
        $display("with bursty requests and a stalling receiver; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
